@@ hw/rtl/ole_pkg.sv @@
// Shared types and constants for the ordered list engine.
// Used by ole_cell, ole_chain and ordered_list_engine_top; no dependencies.
`timescale 1ns / 1ps

package ole_pkg;

	localparam int CAPACITY  = 16;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int DATA_W    = 32;
	localparam int OPC_W     = 3;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	typedef enum logic [OPC_W-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_DEL_HEAD = 3'd2,
		OP_DEL_TAIL = 3'd3,
		OP_DEL_VAL  = 3'd4,
		OP_FIND     = 3'd5,
		OP_CLEAR    = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_NOTFOUND = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_SEARCH = 1'b1
	} state_t;

	// Broadcast control from the sequencer to every cell of the row
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              shift_right;
		logic              shift_left_all;
		logic              shift_left_match;
		logic              write_tail;
		logic              load_hit;
	} cell_ctl_t;

endpackage

@@ hw/rtl/ole_cell.sv @@
// One list cell: holds an entry, shifts it to or from its neighbors,
// and flags a registered match against the search value. Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_cell (
	input  logic                      clk,
	input  ole_pkg::cell_ctl_t        ctl,
	input  logic                      occ,
	input  logic                      wr_sel,
	input  logic [ole_pkg::DATA_W-1:0] left_data,
	input  logic [ole_pkg::DATA_W-1:0] right_data,
	input  logic                      before_in,
	output logic [ole_pkg::DATA_W-1:0] data,
	output logic                      before_out,
	output logic                      first
);
	import ole_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              hit_q;

	assign data       = data_q;
	assign before_out = before_in | hit_q;
	assign first      = hit_q & ~before_in;

	// left shift: all cells, or those at/after the first match, pull right data
	always_ff @(posedge clk) begin
		if (ctl.shift_right) begin
			data_q <= left_data;
		end else if (ctl.shift_left_all || (ctl.shift_left_match && before_out)) begin
			data_q <= right_data;
		end else if (ctl.write_tail && wr_sel) begin
			data_q <= ctl.value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_hit) begin
			hit_q <= occ && (data_q == ctl.value);
		end
	end

endmodule

@@ hw/rtl/ole_chain.sv @@
// Row of list cells with the first-match chain and position encoder.
// Depends on ole_pkg and ole_cell.
`timescale 1ns / 1ps

module ole_chain (
	input  logic                      clk,
	input  ole_pkg::cell_ctl_t        ctl,
	input  logic [ole_pkg::CNT_W-1:0] count,
	output logic                      found,
	output logic [ole_pkg::POS_W-1:0] position
);
	import ole_pkg::*;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY:0] seen;
	logic [CAPACITY-1:0] first;
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] wr_sel;

	assign seen[0] = 1'b0;
	assign found   = seen[CAPACITY];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;

			assign occ[g]    = CNT_W'(g) < count;
			assign wr_sel[g] = CNT_W'(g) == count;

			if (g == 0) begin : g_head
				assign left_d = ctl.value;
			end else begin : g_mid
				assign left_d = cell_data[g-1];
			end

			// the tail cell's right input is never kept: the count drops with it
			if (g == CAPACITY - 1) begin : g_tail
				assign right_d = cell_data[g];
			end else begin : g_body
				assign right_d = cell_data[g+1];
			end

			ole_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.occ        (occ[g]),
				.wr_sel     (wr_sel[g]),
				.left_data  (left_d),
				.right_data (right_d),
				.before_in  (seen[g]),
				.data       (cell_data[g]),
				.before_out (seen[g+1]),
				.first      (first[g])
			);
		end
	endgenerate

	always_comb begin
		position = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				position = position | POS_W'(i + 1);
			end
		end
	end

endmodule

@@ hw/rtl/ordered_list_engine_top.sv @@
// Ordered list engine: bounded deque of signed 32-bit values with search and remove.
// Inserts, head/tail deletes, clear and no-op load the result as accepted; find and
// delete by value compare into every cell, then resolve the first-match chain.
// Throughput: one per cycle for simple ops while output drains; none during a search.
// Result sits in an output register; a new item is taken in the cycle it drains.
// arst_n clears the entry count, sequencer and output valid; cell contents are kept.
`timescale 1ns / 1ps

module ordered_list_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ole_pkg::S_TDATA_W-1:0] s_tdata,  // opcode[2:0], value[34:3], zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ole_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], position[6:2],
	                                                // element_count[11:7], zero pad
);
	import ole_pkg::*;

	state_t            state_q;
	state_t            state_d;
	op_t               op_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              m_tvalid_q;
	status_t           status_q;
	logic [POS_W-1:0]  position_q;
	logic [POS_W-1:0]  elem_cnt_q;

	op_t               s_op;
	logic [DATA_W-1:0] s_value;
	logic              s_accept;
	logic              full;
	logic              empty;
	cell_ctl_t         ctl;
	logic              found;
	logic [POS_W-1:0]  chain_pos;
	logic              res_load;
	status_t           res_status;
	logic [POS_W-1:0]  res_pos;
	logic [31:0]       count_wide;

	assign s_op     = op_t'(s_tdata[OPC_W-1:0]);
	assign s_value  = s_tdata[OPC_W +: DATA_W];
	assign s_accept = s_tvalid && s_tready;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - STAT_W - 2 * POS_W){1'b0}}, elem_cnt_q, position_q, status_q};

	ole_chain u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.count    (count_q),
		.found    (found),
		.position (chain_pos)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept && (s_op == OP_DEL_VAL || s_op == OP_FIND)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready   = 1'b0;
		ctl        = '0;
		ctl.value  = s_value;
		res_load   = 1'b0;
		res_status = STAT_OK;
		res_pos    = '0;
		count_d    = count_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = !m_tvalid_q || m_tready;
				if (s_accept) begin
					res_load = 1'b1;
					case (s_op)
						OP_INS_HEAD: begin
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								ctl.shift_right = 1'b1;
								count_d         = count_q + 1'b1;
							end
						end
						OP_INS_TAIL: begin
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								ctl.write_tail = 1'b1;
								count_d        = count_q + 1'b1;
							end
						end
						OP_DEL_HEAD: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								ctl.shift_left_all = 1'b1;
								count_d            = count_q - 1'b1;
							end
						end
						OP_DEL_TAIL: begin
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						OP_DEL_VAL, OP_FIND: begin
							// hold the result until the match chain resolves
							res_load     = 1'b0;
							ctl.load_hit = 1'b1;
						end
						OP_CLEAR: count_d = '0;
						default:  ;
					endcase
				end
			end
			ST_SEARCH: begin
				res_load = 1'b1;
				if (op_q == OP_DEL_VAL && empty) begin
					res_status = STAT_EMPTY;
				end else if (!found) begin
					res_status = STAT_NOTFOUND;
				end else begin
					res_pos = chain_pos;
					if (op_q == OP_DEL_VAL) begin
						ctl.shift_left_match = 1'b1;
						count_d              = count_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign count_wide = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q <= s_op;
		end
		if (res_load) begin
			status_q   <= res_status;
			position_q <= res_pos;
			elem_cnt_q <= count_wide[POS_W-1:0];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_search_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> !m_tvalid_q)
		else $error("output register busy while resolving a search");

	a_search_entry: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_op == OP_DEL_VAL || s_op == OP_FIND) |=> state_q == ST_SEARCH)
		else $error("search transfer did not enter the resolve cycle");

	a_one_delete: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |=> count_q == $past(count_q) || count_q == $past(count_q) - 1'b1)
		else $error("search removed more than one entry");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for ordered_list_engine_top: directed table, then random list traffic.
// Carries its own model of the deque and depends on ole_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module testbench;
	import ole_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_CAP    = 40;

	typedef struct {
		status_t            status;
		logic [POS_W-1:0]   position;
		logic [CNT_W-1:0]   count;
	} list_result_t;

	typedef struct {
		op_t               op;
		logic [DATA_W-1:0] value;
		int                reps;
		bit                typed;
		status_t           status;
		int                position;
		int                count;
	} stim_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 m_tready = 1'b0;
	wire                  s_tready;
	wire                  m_tvalid;
	wire  [M_TDATA_W-1:0] m_tdata;

	// Model of the list, advanced on every input transfer
	logic [DATA_W-1:0] list_mem [CAPACITY];
	int                list_len = 0;

	list_result_t expected_results [$];
	stim_row_t    stim_rows [$];
	int           fail_count  = 0;
	int           cycle_count = 0;
	bit           burst       = 1'b0;
	bit           hold_req    = 1'b0;

	ordered_list_engine_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, expected_results.size());
			$display("ordered_list_engine_top regression: fail");
			$finish;
		end
	end

	function automatic list_result_t apply_list_op(op_t op, logic [DATA_W-1:0] v);
		list_result_t r;
		int hit;
		int drop_at;
		r.status   = STAT_OK;
		r.position = '0;
		hit        = 0;
		drop_at    = -1;
		for (int i = 0; i < list_len; i++)
			if (hit == 0 && list_mem[i] == v)
				hit = i + 1;
		case (op)
			OP_INS_HEAD: begin
				if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					for (int i = list_len; i > 0; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[0] = v;
					list_len++;
				end
			end
			OP_INS_TAIL: begin
				if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					list_mem[list_len] = v;
					list_len++;
				end
			end
			OP_DEL_HEAD: begin
				if (list_len == 0)
					r.status = STAT_EMPTY;
				else
					drop_at = 0;
			end
			OP_DEL_TAIL: begin
				if (list_len == 0)
					r.status = STAT_EMPTY;
				else
					list_len--;
			end
			OP_DEL_VAL: begin
				if (list_len == 0) begin
					r.status = STAT_EMPTY;
				end else if (hit == 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					r.position = POS_W'(hit);
					drop_at    = hit - 1;
				end
			end
			OP_FIND: begin
				if (hit == 0)
					r.status = STAT_NOTFOUND;
				else
					r.position = POS_W'(hit);
			end
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
		// Close the gap left by a removed entry
		if (drop_at >= 0) begin
			for (int i = drop_at; i + 1 < list_len; i++)
				list_mem[i] = list_mem[i+1];
			list_len--;
		end
		r.count = CNT_W'(list_len);
		return r;
	endfunction

	task automatic add_row(op_t op, logic [DATA_W-1:0] v, int reps, bit typed,
		status_t st, int pos, int cnt);
		stim_row_t row;
		row.op       = op;
		row.value    = v;
		row.reps     = reps;
		row.typed    = typed;
		row.status   = st;
		row.position = pos;
		row.count    = cnt;
		stim_rows.push_back(row);
	endtask

	// Offer one item, hold it until the transfer, then queue its expected result
	task automatic send_item(stim_row_t item, bit drain_first);
		int gap;
		list_result_t r;
		gap = burst ? 0 : $urandom_range(0, 15);
		if (gap > 0 || drain_first) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (drain_first)
				do @(posedge clk); while (expected_results.size() != 0);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-DATA_W-OPC_W){1'b0}}, item.value, item.op};
		do @(posedge clk); while (!s_tready);
		r = apply_list_op(item.op, item.value);
		if (item.typed) begin
			r.status   = item.status;
			r.position = POS_W'(item.position);
			r.count    = CNT_W'(item.count);
		end
		expected_results.push_back(r);
	endtask

	initial begin
		stim_row_t row;
		int r;
		int k;
		int profile;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] value_pool [6];
		int cuts [3][7];

		value_pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A};
		// Cumulative weights per profile: grow, shrink, search-heavy
		cuts = '{'{35, 70, 78, 84, 90, 97, 98},
			'{12, 24, 42, 58, 78, 96, 97},
			'{20, 40, 48, 56, 76, 96, 97}};

		add_row(OP_DEL_HEAD, 32'h0, 1, 1, STAT_EMPTY, 0, 0);
		add_row(OP_DEL_TAIL, 32'h0, 1, 1, STAT_EMPTY, 0, 0);
		add_row(OP_DEL_VAL, 32'h5, 1, 1, STAT_EMPTY, 0, 0);
		add_row(OP_FIND, 32'h5, 1, 1, STAT_NOTFOUND, 0, 0);
		add_row(OP_NOP, 32'hFFFF_FFFF, 1, 1, STAT_OK, 0, 0);
		add_row(OP_CLEAR, 32'h0, 1, 1, STAT_OK, 0, 0);
		add_row(OP_INS_TAIL, 32'h7FFF_FFFF, 1, 1, STAT_OK, 0, 1);
		add_row(OP_INS_HEAD, 32'h8000_0000, 1, 1, STAT_OK, 0, 2);
		add_row(OP_INS_TAIL, 32'h0000_0000, 1, 1, STAT_OK, 0, 3);
		add_row(OP_INS_HEAD, 32'hFFFF_FFFF, 1, 1, STAT_OK, 0, 4);
		add_row(OP_FIND, 32'h8000_0000, 1, 0, STAT_OK, 0, 0);
		add_row(OP_FIND, 32'h0001_2345, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_VAL, 32'h0001_2345, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_VAL, 32'h0000_0000, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_HEAD, 32'h0, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_TAIL, 32'h0, 1, 0, STAT_OK, 0, 0);
		add_row(OP_CLEAR, 32'h0, 1, 1, STAT_OK, 0, 0);
		// Fill with duplicates so first-match and full are both exercised
		add_row(OP_INS_TAIL, 32'h7, CAPACITY, 0, STAT_OK, 0, 0);
		add_row(OP_INS_HEAD, 32'h1, 1, 1, STAT_FULL, 0, CAPACITY);
		add_row(OP_INS_TAIL, 32'h2, 1, 1, STAT_FULL, 0, CAPACITY);
		add_row(OP_FIND, 32'h7, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_VAL, 32'h7, 1, 0, STAT_OK, 0, 0);
		add_row(OP_NOP, 32'h55AA_55AA, 1, 0, STAT_OK, 0, 0);
		add_row(OP_DEL_TAIL, 32'h0, 1, 0, STAT_OK, 0, 0);
		add_row(OP_CLEAR, 32'h0, 1, 1, STAT_OK, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			for (k = 0; k < stim_rows[i].reps; k++)
				send_item(stim_rows[i], 1'b0);

		profile = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				profile = $urandom_range(0, 2);
				burst   = ($urandom_range(0, 3) == 0);
			end
			// Stall the result side for a long stretch while items keep coming
			if (n == 300)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			k = 0;
			while (k < 7 && r >= cuts[profile][k])
				k++;
			if ($urandom_range(0, 9) < 7)
				v = value_pool[$urandom_range(0, 5)];
			else
				v = $urandom;
			row.op    = op_t'(k);
			row.value = v;
			row.reps  = 1;
			row.typed = 1'b0;
			send_item(row, n == 700);
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (expected_results.size() != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("ordered_list_engine_top regression: pass");
		else
			$display("ordered_list_engine_top regression: fail");
		$finish;
	end

	// Result side: random back-pressure and the field-by-field comparison
	initial begin
		list_result_t want;
		status_t got_status;
		logic [POS_W-1:0] got_position;
		logic [CNT_W-1:0] got_count;
		int stall;

		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = burst ? 0 : $urandom_range(0, 15);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);

			got_status   = status_t'(m_tdata[1:0]);
			got_position = m_tdata[6:2];
			got_count    = m_tdata[11:7];
			if (expected_results.size() == 0) begin
				if (fail_count < PRINT_CAP)
					$display("%0t: result with none expected: status %0d position %0d count %0d",
						$time, got_status, got_position, got_count);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (got_status !== want.status || got_position !== want.position ||
					got_count !== want.count) begin
					if (fail_count < PRINT_CAP)
						$display({"%0t: mismatch: expected status %0d position %0d count %0d,",
							" actual status %0d position %0d count %0d"}, $time,
							want.status, want.position, want.count,
							got_status, got_position, got_count);
					fail_count++;
				end
			end
		end
	end

endmodule

@@ filelist.f @@
hw/rtl/ole_pkg.sv
hw/rtl/ole_cell.sv
hw/rtl/ole_chain.sv
hw/rtl/ordered_list_engine_top.sv
dv/testbench.sv
